>>> rtl/bmhq_pkg.sv
// Package for the binary min-heap queue: command and status codes, fixed field
// widths and the sequencer state type.
// No dependencies.
package bmhq_pkg;

  // Fixed widths of the item fields on the ports.
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned OCC_W    = 7;
  localparam int unsigned STATUS_W = 2;

  // Commands carried by an input item.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Status codes carried by a result item.
  localparam logic [STATUS_W-1:0] ST_PUSH_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_DONE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_SU_RD  = 10'b00_0000_0010,
    S_SU_CMP = 10'b00_0000_0100,
    S_POP_R0 = 10'b00_0000_1000,
    S_POP_RL = 10'b00_0001_0000,
    S_POP_LD = 10'b00_0010_0000,
    S_SD_L   = 10'b00_0100_0000,
    S_SD_R   = 10'b00_1000_0000,
    S_SD_W   = 10'b01_0000_0000,
    S_FIN    = 10'b10_0000_0000
  } state_t;

endpackage

>>> rtl/binary_min_heap_queue_unit.sv
// Top level of the binary min-heap priority queue: sequencer, heap RAM and the
// shared compare unit. Depends on bmhq_pkg, bmhq_ram and bmhq_cmp.
//
//   channel | direction | handshake           | fields
//   in_     | in        | in_valid / in_stall   | in_cmd, in_key, in_payload
//   out_    | out       | out_valid / out_stall | out_status, out_key, out_payload,
//           |           |                       | out_occupancy
//
// A rejected push and a pop on an empty heap go straight to the result. Each heap
// level costs one read of the single-read-port heap RAM and one pass through the
// shared compare unit when sifting up, and two reads and two passes when sifting
// down.
// in_stall is high from acceptance until the result enters the output register;
// a held result waits there while the next item is taken.
// Reset clears the entry count, the sequencer and the output valid; the heap RAM
// needs no clearing since a read of a position at or above the entry count is never used.
module binary_min_heap_queue_unit #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned KEY_WIDTH     = 32,
  parameter int unsigned PAYLOAD_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [bmhq_pkg::FIELD_W-1:0]      in_key,
  input  logic [bmhq_pkg::FIELD_W-1:0]      in_payload,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bmhq_pkg::STATUS_W-1:0]     out_status,
  output logic [bmhq_pkg::FIELD_W-1:0]      out_key,
  output logic [bmhq_pkg::FIELD_W-1:0]      out_payload,
  output logic [bmhq_pkg::OCC_W-1:0]        out_occupancy
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = KEY_WIDTH + PAYLOAD_WIDTH;

  // Sequencer and datapath registers.
  bmhq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [EW-1:0]    mov_r, mov_nxt;
  logic [EW-1:0]    best_r, best_nxt;
  logic [IW-1:0]    best_idx_r, best_idx_nxt;
  logic [bmhq_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [KEY_WIDTH-1:0]          res_key_r, res_key_nxt;
  logic [PAYLOAD_WIDTH-1:0]      res_pay_r, res_pay_nxt;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic [bmhq_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [KEY_WIDTH-1:0]          out_key_r, out_key_nxt;
  logic [PAYLOAD_WIDTH-1:0]      out_pay_r, out_pay_nxt;
  logic [bmhq_pkg::OCC_W-1:0]    out_occ_r, out_occ_nxt;

  // RAM port signals.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  // Compare unit signals.
  logic          cmp_cand_ok;
  logic [EW-1:0] cmp_cand_entry;
  logic [IW-1:0] cmp_cand_idx;
  logic [EW-1:0] cmp_inc_entry;
  logic [IW-1:0] cmp_inc_idx;
  logic [EW-1:0] cmp_win_entry;
  logic [IW-1:0] cmp_win_idx;
  logic          cmp_take;

  // Index arithmetic: children and parent of the current position.
  logic [IW:0]   left_x;
  logic [IW:0]   right_x;
  logic [IW:0]   cnt_x;
  logic          left_ok;
  logic          right_ok;
  logic [IW-1:0] parent_idx;
  logic          accept;
  logic          out_free;

  assign left_x     = {idx_r, 1'b1};
  assign right_x    = {idx_r, 1'b0} + (IW+1)'(2);
  assign cnt_x      = (IW+1)'(cnt_r);
  assign left_ok    = left_x < cnt_x;
  assign right_ok   = right_x < cnt_x;
  assign parent_idx = (idx_r - IW'(1)) >> 1;

  assign accept   = (state_r == bmhq_pkg::S_IDLE) && in_valid;
  assign out_free = !out_valid_r || !out_stall;

  bmhq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bmhq_cmp #(
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .IDX_W         (IW)
  ) u_cmp (
    .cand_ok    (cmp_cand_ok),
    .cand_entry (cmp_cand_entry),
    .cand_idx   (cmp_cand_idx),
    .inc_entry  (cmp_inc_entry),
    .inc_idx    (cmp_inc_idx),
    .win_entry  (cmp_win_entry),
    .win_idx    (cmp_win_idx),
    .take       (cmp_take)
  );

  // Compare unit operand selection. Sift-up tests the moving entry against its
  // parent; sift-down tests the left child against the moving entry, then the
  // right child against the winner so far.
  always_comb begin
    cmp_cand_ok    = 1'b1;
    cmp_cand_entry = mov_r;
    cmp_cand_idx   = idx_r;
    cmp_inc_entry  = ram_rdata;
    cmp_inc_idx    = best_idx_r;
    unique case (state_r)
      bmhq_pkg::S_SD_R: begin
        cmp_cand_entry = ram_rdata;
        cmp_cand_idx   = left_x[IW-1:0];
        cmp_inc_entry  = mov_r;
        cmp_inc_idx    = idx_r;
      end
      bmhq_pkg::S_SD_W: begin
        cmp_cand_ok    = right_ok;
        cmp_cand_entry = ram_rdata;
        cmp_cand_idx   = right_x[IW-1:0];
        cmp_inc_entry  = best_r;
        cmp_inc_idx    = best_idx_r;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    mov_nxt        = mov_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_pay_nxt    = res_pay_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = mov_r;
    ram_raddr      = '0;

    unique case (state_r)
      bmhq_pkg::S_IDLE: begin
        if (accept) begin
          res_key_nxt = '0;
          res_pay_nxt = '0;
          if (in_cmd == bmhq_pkg::CMD_PUSH) begin
            if (cnt_r == CW'(CAPACITY)) begin
              res_status_nxt = bmhq_pkg::ST_PUSH_FULL;
              state_nxt      = bmhq_pkg::S_FIN;
            end else begin
              res_status_nxt = bmhq_pkg::ST_PUSH_DONE;
              mov_nxt        = {in_key[KEY_WIDTH-1:0], in_payload[PAYLOAD_WIDTH-1:0]};
              idx_nxt        = cnt_r[IW-1:0];
              cnt_nxt        = cnt_r + CW'(1);
              state_nxt      = bmhq_pkg::S_SU_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              res_status_nxt = bmhq_pkg::ST_POP_EMPTY;
              state_nxt      = bmhq_pkg::S_FIN;
            end else begin
              res_status_nxt = bmhq_pkg::ST_POP_DONE;
              cnt_nxt        = cnt_r - CW'(1);
              state_nxt      = bmhq_pkg::S_POP_R0;
            end
          end
        end
      end

      // Sift-up: stop at the root, otherwise fetch the parent.
      bmhq_pkg::S_SU_RD: begin
        if (idx_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = bmhq_pkg::S_FIN;
        end else begin
          ram_raddr    = parent_idx;
          best_idx_nxt = parent_idx;
          state_nxt    = bmhq_pkg::S_SU_CMP;
        end
      end

      // Sift-up: move the parent down when the moving key is smaller.
      bmhq_pkg::S_SU_CMP: begin
        ram_we = 1'b1;
        if (cmp_take) begin
          ram_wdata = ram_rdata;
          idx_nxt   = best_idx_r;
          state_nxt = bmhq_pkg::S_SU_RD;
        end else begin
          state_nxt = bmhq_pkg::S_FIN;
        end
      end

      // Pop: read the root, then the last entry.
      bmhq_pkg::S_POP_R0: begin
        ram_raddr = '0;
        state_nxt = bmhq_pkg::S_POP_RL;
      end

      bmhq_pkg::S_POP_RL: begin
        ram_raddr   = cnt_r[IW-1:0];
        res_key_nxt = ram_rdata[EW-1:PAYLOAD_WIDTH];
        res_pay_nxt = ram_rdata[PAYLOAD_WIDTH-1:0];
        state_nxt   = bmhq_pkg::S_POP_LD;
      end

      // Pop: the last entry becomes the moving entry at the root.
      bmhq_pkg::S_POP_LD: begin
        mov_nxt = ram_rdata;
        idx_nxt = '0;
        if (cnt_r == '0) begin
          state_nxt = bmhq_pkg::S_FIN;
        end else begin
          state_nxt = bmhq_pkg::S_SD_L;
        end
      end

      // Sift-down: fetch the left child, or settle when there is none.
      bmhq_pkg::S_SD_L: begin
        if (left_ok) begin
          ram_raddr = left_x[IW-1:0];
          state_nxt = bmhq_pkg::S_SD_R;
        end else begin
          ram_we    = 1'b1;
          state_nxt = bmhq_pkg::S_FIN;
        end
      end

      // Sift-down: fetch the right child, compare the left one.
      bmhq_pkg::S_SD_R: begin
        ram_raddr    = right_x[IW-1:0];
        best_nxt     = cmp_win_entry;
        best_idx_nxt = cmp_win_idx;
        state_nxt    = bmhq_pkg::S_SD_W;
      end

      // Sift-down: compare the right child; move the smaller child up or settle.
      bmhq_pkg::S_SD_W: begin
        ram_we = 1'b1;
        if (cmp_win_idx == idx_r) begin
          state_nxt = bmhq_pkg::S_FIN;
        end else begin
          ram_wdata = cmp_win_entry;
          idx_nxt   = cmp_win_idx;
          state_nxt = bmhq_pkg::S_SD_L;
        end
      end

      // Hand the result to the output register once it is free.
      bmhq_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = bmhq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bmhq_pkg::S_IDLE;
      end
    endcase
  end

  // Output register load and drain.
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_pay_nxt    = out_pay_r;
    out_occ_nxt    = out_occ_r;
    if ((state_r == bmhq_pkg::S_FIN) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_key_nxt    = res_key_r;
      out_pay_nxt    = res_pay_r;
      out_occ_nxt    = bmhq_pkg::OCC_W'(cnt_r);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmhq_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    mov_r        <= mov_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_pay_r    <= out_pay_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign in_stall      = (state_r != bmhq_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key       = bmhq_pkg::FIELD_W'(out_key_r);
  assign out_payload   = bmhq_pkg::FIELD_W'(out_pay_r);
  assign out_occupancy = out_occ_r;

endmodule

>>> rtl/bmhq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bmhq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/bmhq_cmp.sv
// Shared key compare and select unit of the heap sequencer.
// Picks the candidate entry over the incumbent when cand_ok is set and its key is strictly smaller.
module bmhq_cmp #(
  parameter int unsigned KEY_WIDTH     = 32,
  parameter int unsigned PAYLOAD_WIDTH = 32,
  parameter int unsigned IDX_W         = 6
) (
  input  logic                               cand_ok,
  input  logic [KEY_WIDTH+PAYLOAD_WIDTH-1:0] cand_entry,
  input  logic [IDX_W-1:0]                   cand_idx,
  input  logic [KEY_WIDTH+PAYLOAD_WIDTH-1:0] inc_entry,
  input  logic [IDX_W-1:0]                   inc_idx,
  output logic [KEY_WIDTH+PAYLOAD_WIDTH-1:0] win_entry,
  output logic [IDX_W-1:0]                   win_idx,
  output logic                               take
);

  localparam int unsigned EW = KEY_WIDTH + PAYLOAD_WIDTH;

  logic [KEY_WIDTH-1:0] cand_key;
  logic [KEY_WIDTH-1:0] inc_key;

  assign cand_key = cand_entry[EW-1:PAYLOAD_WIDTH];
  assign inc_key  = inc_entry[EW-1:PAYLOAD_WIDTH];

  // Strict less-than, so equal keys never displace the incumbent.
  assign take      = cand_ok && (cand_key < inc_key);
  assign win_entry = take ? cand_entry : inc_entry;
  assign win_idx   = take ? cand_idx : inc_idx;

endmodule
